FILE: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also covers reset cycles
`define ASSERT_CLK_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/bfba_pkg.sv
// shared types and constants of the bloom filter bit array
// no dependencies
package bfba_pkg;

    localparam int MAX_BITS_DEF = 4096;
    localparam int WORD_W       = 32;
    localparam int FBITS_W      = 13;
    localparam int HCNT_W       = 7;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int LANES        = 4;
    localparam int LANE_IDX_W   = 2;
    localparam int RED_CNT_W    = 5;

    localparam logic [FBITS_W-1:0]   FBITS_RESET = 13'd4096;
    localparam logic [HCNT_W-1:0]    HCNT_RESET  = 7'd4;
    localparam logic [HCNT_W-1:0]    K_DEFAULT   = 7'd4;
    localparam logic [HCNT_W-1:0]    K_LIMIT     = 7'd64;
    localparam logic [RED_CNT_W-1:0] RED_LAST    = 5'd31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_BITS = 1'b0,
        CFG_HASH_COUNT  = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_TEST   = 1'b1
    } t_opcode;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_REDUCE = 6'b000100,
        ST_ACCESS = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_FINISH = 6'b100000
    } t_state;

    typedef struct packed {
        logic                  clear;
        logic                  load;
        logic                  red_step;
        logic                  acc;
        logic [LANE_IDX_W-1:0] acc_idx;
        logic                  finish;
        logic                  out_load;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       last;
        logic       test;
        logic [2:0] nwords;
    } t_sts;

endpackage

FILE: src/bfba_ctrl.sv
// sequencer of the bloom filter bit array: clear sweep, reduce, access, drain, finish
// depends on bfba_pkg
module bfba_ctrl import bfba_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state                r_state, n_state;
    logic [RED_CNT_W-1:0]  r_cnt, n_cnt;
    logic [LANE_IDX_W-1:0] r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    logic                  need_out;

    assign need_out = i_sts.last && i_sts.test;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.acc_idx = r_idx;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                o_cmd.red_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == RED_LAST) begin
                    n_idx   = '0;
                    n_state = ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                o_cmd.acc = 1'b1;
                if ({1'b0, r_idx} == i_sts.nwords - 3'd1) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!(need_out && r_out_valid && i_out_stall)) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.out_load = need_out;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: src/bfba_dpath.sv
// datapath of the bloom filter bit array: config, four modulo lanes, bit memory
// depends on bfba_pkg
module bfba_dpath import bfba_pkg::*; #(
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_opcode,
    input  logic [WORD_W-1:0]     i_digest_word_0,
    input  logic [WORD_W-1:0]     i_digest_word_1,
    input  logic [WORD_W-1:0]     i_digest_word_2,
    input  logic [WORD_W-1:0]     i_digest_word_3,
    output logic                  o_present,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts
);

    localparam int IDX_W = $clog2(MAX_BITS);
    localparam int M_W   = $clog2(MAX_BITS + 1);

    logic [FBITS_W-1:0] r_fbits;
    logic [HCNT_W-1:0]  r_hcnt;
    logic [M_W-1:0]     r_m, n_m;
    logic [FBITS_W:0]   fb_round;
    logic               fb_sat;

    logic [HCNT_W-1:0] k_eff;
    logic [4:0]        rounds;
    logic              n_last;
    logic [2:0]        n_nwords;

    logic [WORD_W-1:0] r_word [LANES];
    logic [M_W-1:0]    r_rem  [LANES];
    logic [M_W-1:0]    n_rem  [LANES];
    logic [M_W:0]      shifted [LANES];
    logic [WORD_W-1:0] lane_in [LANES];

    logic             r_mem [MAX_BITS];
    logic [IDX_W-1:0] r_clr_addr;
    logic [IDX_W-1:0] acc_addr;
    logic             r_rd_data;
    logic             r_rd_chk;

    logic       r_test, r_last;
    logic [2:0] r_nwords;
    logic [3:0] r_round;
    logic       r_present;
    logic       r_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fbits <= FBITS_RESET;
            r_hcnt  <= HCNT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FILTER_BITS: r_fbits <= i_cfg_data[FBITS_W-1:0];
                CFG_HASH_COUNT:  r_hcnt  <= i_cfg_data[HCNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective bit count
    assign fb_round = ({1'b0, r_fbits} + (FBITS_W+1)'(7)) & ~(FBITS_W+1)'(7);
    assign fb_sat   = 32'(fb_round) > 32'(MAX_BITS);
    assign n_m      = (r_fbits == '0) ? M_W'(8) :
                      fb_sat          ? M_W'(MAX_BITS) : M_W'(fb_round);

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
    end

    // effective hash count and round bookkeeping
    assign k_eff    = (r_hcnt == '0)     ? K_DEFAULT :
                      (r_hcnt > K_LIMIT) ? K_LIMIT   : r_hcnt;
    assign rounds   = 5'(({1'b0, k_eff} + 8'd3) >> 2);
    assign n_last   = ({1'b0, r_round} + 5'd1) >= rounds;
    assign n_nwords = (n_last && (k_eff[1:0] != 2'd0)) ? {1'b0, k_eff[1:0]} : 3'd4;

    // modulo lanes, one quotient bit a cycle while red_step is set
    assign lane_in[0] = i_digest_word_0;
    assign lane_in[1] = i_digest_word_1;
    assign lane_in[2] = i_digest_word_2;
    assign lane_in[3] = i_digest_word_3;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            shifted[l] = {r_rem[l], r_word[l][WORD_W-1]};
            if (shifted[l] >= {1'b0, r_m}) begin
                n_rem[l] = M_W'(shifted[l] - {1'b0, r_m});
            end else begin
                n_rem[l] = M_W'(shifted[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_cmd.load) begin
                r_word[l] <= lane_in[l];
                r_rem[l]  <= '0;
            end else if (i_cmd.red_step) begin
                r_word[l] <= {r_word[l][WORD_W-2:0], 1'b0};
                r_rem[l]  <= n_rem[l];
            end
        end
        if (i_cmd.load) begin
            r_test   <= (t_opcode'(i_opcode) == OP_TEST);
            r_last   <= n_last;
            r_nwords <= n_nwords;
        end
    end

    // bit memory with clear sweep
    assign acc_addr = r_rem[i_cmd.acc_idx][IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.acc && !r_test) begin
            r_mem[acc_addr] <= 1'b1;
        end
        r_rd_data <= r_mem[acc_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_rd_chk   <= 1'b0;
            r_round    <= '0;
            r_present  <= 1'b1;
        end else begin
            if (i_cmd.clear && !o_sts.clr_done) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_rd_chk <= i_cmd.acc && r_test;
            if (i_cmd.finish) begin
                if (r_last) begin
                    r_round   <= '0;
                    r_present <= 1'b1;
                end else begin
                    r_round <= r_round + 1'b1;
                end
            end else if (r_rd_chk) begin
                r_present <= r_present & r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= r_present;
        end
    end

    assign o_present       = r_out;
    assign o_sts.clr_done  = (r_clr_addr == IDX_W'(MAX_BITS - 1));
    assign o_sts.last      = r_last;
    assign o_sts.test      = r_test;
    assign o_sts.nwords    = r_nwords;

endmodule

FILE: src/bloom_filter_bit_array.sv
// top level of the bloom filter bit array engine
// depends on bfba_pkg, bfba_ctrl, bfba_dpath
//
// input channel: i_in_valid / o_in_stall carry one request, an opcode (insert or
// test) and one 128-bit digest as four 32-bit words. an element spans
// ceil(k/4) requests; the last one uses k mod 4 words (4 when that is zero).
// output channel: o_out_valid / i_out_stall carry o_present, one result after
// the last request of a test element. inserts give no result.
// config: i_cfg_we writes i_cfg_data to register i_cfg_index (0 filter_bits,
// 1 hash_count); the user writes only while the block is idle (not enforced).
// timing: after acceptance a request runs the four parallel bit-serial modulo
// lanes, then one access per word on the single port of the bit memory, then
// drain and finish, before the next request can be accepted.
// reset: the bit memory is swept to zero, one bit per cycle, with o_in_stall
// high; config writes are taken during the sweep.
// a stalled result sits in the output register while the next request is
// worked on; a further result waits in the finish step until it is taken.
module bloom_filter_bit_array import bfba_pkg::*; #(
    parameter int MAX_BITS = MAX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  logic [WORD_W-1:0]     i_digest_word_0,
    input  logic [WORD_W-1:0]     i_digest_word_1,
    input  logic [WORD_W-1:0]     i_digest_word_2,
    input  logic [WORD_W-1:0]     i_digest_word_3,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_present
);

    t_cmd cmd;
    t_sts sts;

    bfba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfba_dpath #(
        .MAX_BITS (MAX_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_digest_word_0 (i_digest_word_0),
        .i_digest_word_1 (i_digest_word_1),
        .i_digest_word_2 (i_digest_word_2),
        .i_digest_word_3 (i_digest_word_3),
        .o_present       (o_present),
        .i_cmd           (cmd),
        .o_sts           (sts)
    );

endmodule

FILE: src/bfba_checker.sv
// port-level checks of the bloom filter bit array, bound to the top level
// depends on assert_macros.svh and bfba_pkg
`include "assert_macros.svh"

module bfba_checker import bfba_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              i_opcode,
    input logic [WORD_W-1:0] i_digest_word_0,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_present
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_present), "stalled result changed")
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall |=> i_in_valid && $stable(i_opcode) && $stable(i_digest_word_0), "stalled request changed")
    `ASSERT_CLK(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "request taken while busy")
    `ASSERT_CLK(a_min_latency, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall, 30), "result too soon after idle")
    `ASSERT_CLK_RST(a_reset_state, i_clk, !i_rst_n |=> o_in_stall && !o_out_valid, "reset did not stall or clear output")

endmodule

bind bloom_filter_bit_array bfba_checker u_bfba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_opcode        (i_opcode),
    .i_digest_word_0 (i_digest_word_0),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_present       (o_present)
);

FILE: tb/bloom_filter_bit_array_test.sv
// self-checking testbench for the bloom filter bit array engine
// depends on bfba_pkg and bloom_filter_bit_array; a scoreboard class predicts presence
// directed requests cover the corner cases, then random elements run under several configs
module bloom_filter_bit_array_test;
    import bfba_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 60;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned LONG_HOLD      = 1500;
    localparam int unsigned KEY_STORE      = 48;

    class bloom_membership_board;
        bit                 filter_array [MAX_BITS_DEF];
        int unsigned        round_idx;
        bit                 running_present;
        logic [FBITS_W-1:0] filter_bits;
        logic [HCNT_W-1:0]  hash_count;
        bit                 expected_present [$];
        int unsigned        mismatches;

        function new();
            round_idx       = 0;
            running_present = 1'b1;
            filter_bits     = FBITS_RESET;
            hash_count      = HCNT_RESET;
            mismatches      = 0;
        endfunction

        function void set_register(t_cfg_reg which, logic [CFG_DATA_W-1:0] value);
            case (which)
                CFG_FILTER_BITS: filter_bits = value[FBITS_W-1:0];
                CFG_HASH_COUNT:  hash_count  = value[HCNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned hash_k();
            int unsigned k;
            k = (hash_count == 0) ? int'(K_DEFAULT) : int'(hash_count);
            if (k > K_LIMIT)
                k = K_LIMIT;
            return k;
        endfunction

        // digests still needed to close the current element
        function int unsigned rounds_left();
            int unsigned rounds;
            rounds = (hash_k() + 3) / 4;
            return (round_idx + 1 >= rounds) ? 1 : rounds - round_idx;
        endfunction

        function void note_digest(t_opcode op, logic [LANES-1:0][WORD_W-1:0] words);
            int unsigned m;
            int unsigned k;
            int unsigned nwords;
            int unsigned idx;
            int unsigned j;
            bit          last;
            m = (filter_bits == 0) ? 8 : ((int'(filter_bits) + 7) & ~7);
            if (m > MAX_BITS_DEF)
                m = MAX_BITS_DEF;
            k = hash_k();
            last = (round_idx + 1) >= ((k + 3) / 4);
            nwords = (last && (k % 4 != 0)) ? k % 4 : LANES;
            for (j = 0; j < nwords; j++) begin
                idx = words[j] % m;
                if (op == OP_TEST)
                    running_present &= filter_array[idx];
                else
                    filter_array[idx] = 1'b1;
            end
            if (!last) begin
                round_idx = (round_idx + 1) & 15;
            end else begin
                if (op == OP_TEST)
                    expected_present.push_back(running_present);
                round_idx       = 0;
                running_present = 1'b1;
            end
        endfunction

        function int unsigned pending();
            return expected_present.size();
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_present(logic got);
            bit want;
            if (expected_present.size() == 0) begin
                report_mismatch($sformatf("present %b with no result expected", got));
            end else begin
                want = expected_present.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("present got %b expected %b", got, want));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_opcode;
    logic [WORD_W-1:0]     i_digest_word_0;
    logic [WORD_W-1:0]     i_digest_word_1;
    logic [WORD_W-1:0]     i_digest_word_2;
    logic [WORD_W-1:0]     i_digest_word_3;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_present;

    bloom_membership_board sb = new();
    int unsigned           send_gap_pct;
    int unsigned           stall_pct;
    int unsigned           sent_items;
    bit                    hold_request;
    logic [WORD_W-1:0]     known_keys [$];

    bloom_filter_bit_array i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_digest_word_0 (i_digest_word_0),
        .i_digest_word_1 (i_digest_word_1),
        .i_digest_word_2 (i_digest_word_2),
        .i_digest_word_3 (i_digest_word_3),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_present       (o_present)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side stall, with a long hold-off when hold_request is set
    initial begin
        int unsigned held;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (held = 0; held < LONG_HOLD; held++) begin
                    i_out_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_present(o_present);
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_request(t_opcode op, logic [LANES-1:0][WORD_W-1:0] words);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_digest_word_0 <= words[0];
        i_digest_word_1 <= words[1];
        i_digest_word_2 <= words[2];
        i_digest_word_3 <= words[3];
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        sb.note_digest(op, words);
        sent_items++;
    endtask

    task automatic drain_results(int unsigned extra_cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (extra_cycles) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_reg which, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_register(which, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [FBITS_W-1:0] fb, logic [HCNT_W-1:0] hc);
        drain_results(SETTLE_CYCLES);
        write_register(CFG_FILTER_BITS, fb);
        write_register(CFG_HASH_COUNT, hc);
    endtask

    // digest words are derived from the key, so an inserted key can be tested again
    task automatic send_element(t_opcode op, logic [WORD_W-1:0] key, bit mixed);
        int unsigned                  count;
        int unsigned                  r;
        int unsigned                  j;
        logic [WORD_W-1:0]            mix;
        logic [LANES-1:0][WORD_W-1:0] words;
        t_opcode                      this_op;
        count = sb.rounds_left();
        for (r = 0; r < count; r++) begin
            for (j = 0; j < LANES; j++) begin
                mix = key ^ ((r * LANES + j) * 32'h9E37_79B9);
                mix = mix ^ (mix >> 16);
                mix = mix * 32'h85EB_CA6B;
                mix = mix ^ (mix >> 13);
                mix = mix * 32'hC2B2_AE35;
                words[j] = mix ^ (mix >> 16);
            end
            if (mixed)
                this_op = ($urandom_range(1) == 0) ? OP_INSERT : OP_TEST;
            else
                this_op = op;
            send_request(this_op, words);
        end
    endtask

    task automatic run_phase(logic [FBITS_W-1:0] fb, logic [HCNT_W-1:0] hc,
                             int unsigned items);
        int unsigned                  stop_at;
        int unsigned                  pick;
        int unsigned                  j;
        logic [WORD_W-1:0]            key;
        logic [LANES-1:0][WORD_W-1:0] words;
        configure(fb, hc);
        stop_at = sent_items + items;
        while (sent_items < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 40 || known_keys.size() == 0) begin
                key = $urandom;
                send_element(OP_INSERT, key, $urandom_range(19) == 0);
                known_keys.push_back(key);
                if (known_keys.size() > KEY_STORE)
                    void'(known_keys.pop_front());
            end else if (pick < 75) begin
                send_element(OP_TEST, known_keys[$urandom_range(known_keys.size() - 1)],
                             $urandom_range(19) == 0);
            end else if (pick < 90) begin
                send_element(OP_TEST, $urandom, 1'b0);
            end else begin
                // stray request with raw words
                for (j = 0; j < LANES; j++) begin
                    case ($urandom_range(7))
                        0: words[j] = '0;
                        1: words[j] = '1;
                        2: words[j] = 32'd1 << $urandom_range(31);
                        default: words[j] = $urandom;
                    endcase
                end
                send_request(($urandom_range(1) == 0) ? OP_INSERT : OP_TEST, words);
            end
            if ($urandom_range(49) == 0)
                drain_results(0);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_FILTER_BITS;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_opcode        = OP_INSERT;
        i_digest_word_0 = '0;
        i_digest_word_1 = '0;
        i_digest_word_2 = '0;
        i_digest_word_3 = '0;
        send_gap_pct    = 0;
        stall_pct       = 0;
        sent_items      = 0;
        hold_request    = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part; digest words are listed from word 3 down to word 0
        configure(13'd16, 7'd4);
        send_request(OP_INSERT, {32'd15, 32'd1, 32'hFFFF_FFFF, 32'd0});
        send_request(OP_TEST,   {32'd15, 32'd1, 32'hFFFF_FFFF, 32'd0});
        send_request(OP_TEST,   {32'd2, 32'd0, 32'd0, 32'd0});
        send_request(OP_TEST,   {32'd17, 32'hFFFF_FFF0, 32'd31, 32'd16});

        // mixed opcodes within a two digest element
        configure(13'd16, 7'd8);
        send_request(OP_INSERT, {32'd5, 32'd4, 32'd3, 32'd2});
        send_request(OP_TEST,   {32'd5, 32'd4, 32'd3, 32'd2});
        send_request(OP_TEST,   {32'd9, 32'd8, 32'd7, 32'd6});
        send_request(OP_INSERT, {32'd9, 32'd8, 32'd7, 32'd6});
        send_request(OP_TEST,   {32'd9, 32'd8, 32'd7, 32'd6});
        send_request(OP_TEST,   {32'd15, 32'd15, 32'd1, 32'd0});

        // hash count lowered while an element is half done
        send_request(OP_TEST, {32'd13, 32'd12, 32'd11, 32'd10});
        configure(13'd16, 7'd4);
        send_request(OP_TEST, {32'd3, 32'd2, 32'd1, 32'd0});

        // zero bit count and zero hash count fall back to defaults
        configure(13'd0, 7'd0);
        send_request(OP_INSERT, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_request(OP_TEST,   {32'hFFFF_FFFF, 32'd23, 32'd15, 32'd7});

        // partial last digest, one word in use
        configure(13'd1, 7'd5);
        send_request(OP_TEST, {32'd7, 32'd7, 32'd7, 32'd7});
        send_request(OP_TEST, {32'd7, 32'd7, 32'd7, 32'd3});

        // bit count above the array size saturates
        configure(13'd4100, 7'd3);
        send_request(OP_INSERT, {32'd0, 32'hFFFF_FFFF, 32'd4096, 32'd4095});
        send_request(OP_TEST,   {32'd0, 32'hFFFF_FFFF, 32'd4096, 32'd4095});

        configure(13'd8191, 7'd7);
        send_request(OP_INSERT, {32'h8000_0000, 32'h0123_4567, 32'h89AB_CDEF, 32'h5555_5555});
        send_request(OP_TEST,   {32'h0000_0001, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0});

        // random part
        send_gap_pct = 27;
        stall_pct    = 83;
        run_phase(13'd4096, 7'd4, 150);
        run_phase(13'd0, 7'd0, 80);
        run_phase(13'd100, 7'd9, 120);

        send_gap_pct = 83;
        stall_pct    = 27;
        run_phase(13'd8191, 7'd64, 200);
        run_phase(13'd1, 7'd1, 80);
        run_phase(13'd777, 7'd127, 120);

        send_gap_pct = 0;
        stall_pct    = 0;
        // back pressure: results held off while tests keep coming
        configure(13'd5000, 7'd3);
        hold_request = 1'b1;
        repeat (12) send_element(OP_TEST, $urandom, 1'b0);
        run_phase(13'd5000, 7'd3, 100);
        run_phase(13'd4095, 7'd6, 150);
        run_phase(13'd64, 7'd2, 100);

        drain_results(SETTLE_CYCLES);
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: files.f
+incdir+src
src/bfba_pkg.sv
src/bfba_ctrl.sv
src/bfba_dpath.sv
src/bloom_filter_bit_array.sv
src/bfba_checker.sv
tb/bloom_filter_bit_array_test.sv
